>>> rtl/core/gru_cell_pointwise_update_core_defines.svh
// gru_cell_pointwise_update_core_defines.svh: assertion macros for the gru pointwise core
// expects clk and arst_n in the scope where a macro is used
`ifndef GRU_CELL_POINTWISE_UPDATE_CORE_DEFINES_SVH
`define GRU_CELL_POINTWISE_UPDATE_CORE_DEFINES_SVH

// consequent must hold in the same cycle
`define GCPU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the following cycle
`define GCPU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/gcpu_pkg.sv
// gcpu_pkg.sv: constants, codes and activation tables of the gru pointwise core
// no dependencies; the tables are built at elaboration
package gcpu_pkg;

	localparam int HIDDEN_UNITS      = 512;
	localparam int ACT_TABLE_ENTRIES = 256;
	localparam int NUM_BIAS_SLOTS    = 6;

	localparam logic [63:0] Q30_ONE = 64'd1 << 30;

	// item action codes
	localparam logic ACT_COMPUTE = 1'b0;
	localparam logic ACT_WRITE   = 1'b1;

	// bias slots: input z,r,g then recurrent z,r,g
	typedef enum logic [2:0] {
		SLOT_IN_Z  = 3'd0,
		SLOT_IN_R  = 3'd1,
		SLOT_IN_G  = 3'd2,
		SLOT_REC_Z = 3'd3,
		SLOT_REC_R = 3'd4,
		SLOT_REC_G = 3'd5
	} bias_slot_t;

	// configuration register indexes (word address)
	typedef enum logic [1:0] {
		REG_TRAINING_MODE       = 2'd0,
		REG_ZONEOUT_ENABLE      = 2'd1,
		REG_ZONEOUT_PROBABILITY = 2'd2
	} cfg_reg_t;

	typedef logic [12:0] sig_tab_t  [ACT_TABLE_ENTRIES + 1];
	typedef logic [13:0] tanh_tab_t [ACT_TABLE_ENTRIES + 1];

	// shift and subtract division, elaboration only
	function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
		logic [63:0] q;
		logic [63:0] rem;
		q   = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], n[b]};
			if (rem >= d) begin
				rem  = rem - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-a) in q30: taylor series on a/256, squared eight times
	function automatic logic [63:0] exp_neg_q30(logic [63:0] a);
		logic [63:0] u;
		logic [63:0] t2;
		logic [63:0] t3;
		logic [63:0] t4;
		logic [63:0] e;
		u  = a >> 8;
		t2 = (u * u) >> 30;
		t3 = (t2 * u) >> 30;
		t4 = (t3 * u) >> 30;
		e  = (Q30_ONE - u) + t2 / 2 - t3 / 6 + t4 / 24;
		for (int i = 0; i < 8; i++) begin
			e = (e * e + (Q30_ONE >> 1)) >> 30;
		end
		return e;
	endfunction

	// e^(-|x|) for table point k
	function automatic logic [63:0] point_exp(int k);
		longint m;
		logic [63:0] mag;
		logic [63:0] a;
		m   = 16 * longint'(k) - 8 * longint'(ACT_TABLE_ENTRIES);
		mag = (m < 0) ? 64'(-m) : 64'(m);
		a   = (mag << 30) / ACT_TABLE_ENTRIES;
		return exp_neg_q30(a);
	endfunction

	function automatic sig_tab_t build_sig_tab();
		sig_tab_t t;
		logic [63:0] e;
		logic [63:0] den;
		logic [63:0] sp;
		for (int k = 0; k <= ACT_TABLE_ENTRIES; k++) begin
			e   = point_exp(k);
			den = Q30_ONE + e;
			sp  = udiv64(64'd4096 * Q30_ONE + (den >> 1), den);
			t[k] = (2 * k < ACT_TABLE_ENTRIES) ? 13'(64'd4096 - sp) : 13'(sp);
		end
		return t;
	endfunction

	// tanh points are offset by 4096 so they stay unsigned
	function automatic tanh_tab_t build_tanh_tab();
		tanh_tab_t t;
		logic [63:0] e;
		logic [63:0] e2;
		logic [63:0] den2;
		logic [63:0] tm;
		for (int k = 0; k <= ACT_TABLE_ENTRIES; k++) begin
			e    = point_exp(k);
			e2   = (e * e + (Q30_ONE >> 1)) >> 30;
			den2 = Q30_ONE + e2;
			tm   = udiv64(64'd4096 * (Q30_ONE - e2) + (den2 >> 1), den2);
			t[k] = (2 * k < ACT_TABLE_ENTRIES) ? 14'(64'd4096 - tm) : 14'(64'd4096 + tm);
		end
		return t;
	endfunction

	localparam sig_tab_t  SIG_TAB  = build_sig_tab();
	localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

>>> rtl/core/gru_cell_pointwise_update_core.sv
// gru_cell_pointwise_update_core.sv: gru gates, state update and zoneout, one element a cycle
// when not stalled; depends on gcpu_pkg and gru_cell_pointwise_update_core_defines.svh
//
// channel   direction  handshake           payload
// in        sink       in_valid/in_stall    action, unit_index, bias_slot, bias_value,
//                                           wx_*, rh_*, h_prev, keep_new
// out       source     out_valid/out_stall  h_new, gate_*, recurrent_candidate_sum
// cfg       apb slave  psel/penable/pready  training_mode, zoneout_enable, zoneout_probability
//
// twelve register stages; one item per cycle sustained unless out_stall backs up the pipeline
// bias writes land in the six bias banks at transfer and make no result
// each stage loads when it is empty or the next one loads, so bubbles close under stall
// reset clears valid bits and config; bias banks hold garbage until written

module gru_cell_pointwise_update_core #(
	parameter int HIDDEN_UNITS = gcpu_pkg::HIDDEN_UNITS
) (
	input  logic               clk,
	input  logic               arst_n,
	// item input
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic [8:0]         unit_index,
	input  logic [2:0]         bias_slot,
	input  logic signed [15:0] bias_value,
	input  logic signed [15:0] wx_update,
	input  logic signed [15:0] wx_reset,
	input  logic signed [15:0] wx_candidate,
	input  logic signed [15:0] rh_update,
	input  logic signed [15:0] rh_reset,
	input  logic signed [15:0] rh_candidate,
	input  logic signed [15:0] h_prev,
	input  logic               keep_new,
	// result output
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] h_new,
	output logic [12:0]        gate_update,
	output logic [12:0]        gate_reset,
	output logic signed [13:0] gate_candidate,
	output logic signed [15:0] recurrent_candidate_sum,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int NS = 12;
	localparam int AW = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
	localparam int N  = gcpu_pkg::ACT_TABLE_ENTRIES;
	localparam int IW = $clog2(N);
	localparam int PW = 16 + IW + 1;

	function automatic logic signed [15:0] sat16(logic signed [31:0] v);
		if (v > 32'sd32767) return 16'sh7fff;
		if (v < -32'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	// round half up from q.24 to q.12
	function automatic logic signed [19:0] round12(logic signed [31:0] v);
		logic signed [31:0] t;
		t = (v + 32'sd2048) >>> 12;
		return t[19:0];
	endfunction

	// ---------------------------------------------------------------
	// configuration registers
	logic        training_mode_q;
	logic        zoneout_enable_q;
	logic [12:0] zoneout_probability_q;
	logic        cfg_wr;
	gcpu_pkg::cfg_reg_t cfg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_sel = gcpu_pkg::cfg_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			training_mode_q       <= 1'b0;
			zoneout_enable_q      <= 1'b0;
			zoneout_probability_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				gcpu_pkg::REG_TRAINING_MODE:       training_mode_q       <= pwdata[0];
				gcpu_pkg::REG_ZONEOUT_ENABLE:      zoneout_enable_q      <= pwdata[0];
				gcpu_pkg::REG_ZONEOUT_PROBABILITY: zoneout_probability_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (cfg_sel)
			gcpu_pkg::REG_TRAINING_MODE:       prdata = {31'b0, training_mode_q};
			gcpu_pkg::REG_ZONEOUT_ENABLE:      prdata = {31'b0, zoneout_enable_q};
			gcpu_pkg::REG_ZONEOUT_PROBABILITY: prdata = {19'b0, zoneout_probability_q};
			default:                           prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// pipeline flow control
	logic [NS-1:0] vld_q;
	logic [NS-1:0] adv;
	logic          in_xfer;
	logic          unit_ok;

	always_comb begin
		adv[NS-1] = !vld_q[NS-1] || !out_stall;
		for (int k = NS - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k + 1];
		end
	end

	assign in_stall  = !adv[0];
	assign in_xfer   = in_valid && adv[0];
	assign out_valid = vld_q[NS-1];
	assign unit_ok   = 32'(unit_index) < 32'(HIDDEN_UNITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= in_valid && (action == gcpu_pkg::ACT_COMPUTE);
			for (int k = 1; k < NS; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k - 1];
			end
		end
	end

	// ---------------------------------------------------------------
	// stage 1: bias banks, one per slot, read with the transfer
	logic signed [15:0] bias_s1 [gcpu_pkg::NUM_BIAS_SLOTS];
	logic [AW-1:0]      bank_addr;

	assign bank_addr = AW'(unit_index);

	for (genvar s = 0; s < gcpu_pkg::NUM_BIAS_SLOTS; s++) begin : g_bank
		logic signed [15:0] bank_mem [HIDDEN_UNITS];
		logic               bank_we;

		assign bank_we = in_xfer && (action == gcpu_pkg::ACT_WRITE) && unit_ok
			&& (bias_slot == 3'(s));

		always_ff @(posedge clk) begin
			if (bank_we) bank_mem[bank_addr] <= bias_value;
			if (adv[0]) bias_s1[s] <= bank_mem[bank_addr];
		end
	end

	logic signed [15:0] wxz_s1, wxr_s1, wxg_s1, rhz_s1, rhr_s1, rhg_s1, hp_s1;
	logic               keep_s1, unit_ok_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			wxz_s1     <= wx_update;
			wxr_s1     <= wx_reset;
			wxg_s1     <= wx_candidate;
			rhz_s1     <= rh_update;
			rhr_s1     <= rh_reset;
			rhg_s1     <= rh_candidate;
			hp_s1      <= h_prev;
			keep_s1    <= keep_new;
			unit_ok_s1 <= unit_ok;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: gate pre-activation sums, out-of-range units see zero bias
	logic signed [15:0] b_in_z, b_in_r, b_in_g, b_rec_z, b_rec_r, b_rec_g;
	logic signed [15:0] sz_s2, sr_s2, c_s2, wxg_s2, bxg_s2, hp_s2;
	logic               keep_s2;

	assign b_in_z  = unit_ok_s1 ? bias_s1[gcpu_pkg::SLOT_IN_Z]  : '0;
	assign b_in_r  = unit_ok_s1 ? bias_s1[gcpu_pkg::SLOT_IN_R]  : '0;
	assign b_in_g  = unit_ok_s1 ? bias_s1[gcpu_pkg::SLOT_IN_G]  : '0;
	assign b_rec_z = unit_ok_s1 ? bias_s1[gcpu_pkg::SLOT_REC_Z] : '0;
	assign b_rec_r = unit_ok_s1 ? bias_s1[gcpu_pkg::SLOT_REC_R] : '0;
	assign b_rec_g = unit_ok_s1 ? bias_s1[gcpu_pkg::SLOT_REC_G] : '0;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			sz_s2   <= sat16(32'(wxz_s1) + 32'(rhz_s1) + 32'(b_in_z) + 32'(b_rec_z));
			sr_s2   <= sat16(32'(wxr_s1) + 32'(rhr_s1) + 32'(b_in_r) + 32'(b_rec_r));
			c_s2    <= sat16(32'(rhg_s1) + 32'(b_rec_g));
			wxg_s2  <= wxg_s1;
			bxg_s2  <= b_in_g;
			hp_s2   <= hp_s1;
			keep_s2 <= keep_s1;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: sigmoid table fetch for z and r
	logic [PW-1:0]      pz, pr;
	logic [IW:0]        iz0, iz1, ir0, ir1;
	logic [12:0]        zt0_s3, rt0_s3;
	logic signed [14:0] zd_s3, rd_s3;
	logic [15:0]        zf_s3, rf_s3;
	logic signed [15:0] c_s3, wxg_s3, bxg_s3, hp_s3;
	logic               keep_s3;

	assign pz  = PW'({~sz_s2[15], sz_s2[14:0]}) * PW'(N);
	assign pr  = PW'({~sr_s2[15], sr_s2[14:0]}) * PW'(N);
	assign iz0 = {1'b0, pz[16+IW-1:16]};
	assign iz1 = iz0 + 1'b1;
	assign ir0 = {1'b0, pr[16+IW-1:16]};
	assign ir1 = ir0 + 1'b1;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			zt0_s3  <= gcpu_pkg::SIG_TAB[iz0];
			zd_s3   <= $signed({2'b0, gcpu_pkg::SIG_TAB[iz1]}) - $signed({2'b0, gcpu_pkg::SIG_TAB[iz0]});
			zf_s3   <= pz[15:0];
			rt0_s3  <= gcpu_pkg::SIG_TAB[ir0];
			rd_s3   <= $signed({2'b0, gcpu_pkg::SIG_TAB[ir1]}) - $signed({2'b0, gcpu_pkg::SIG_TAB[ir0]});
			rf_s3   <= pr[15:0];
			c_s3    <= c_s2;
			wxg_s3  <= wxg_s2;
			bxg_s3  <= bxg_s2;
			hp_s3   <= hp_s2;
			keep_s3 <= keep_s2;
		end
	end

	// ---------------------------------------------------------------
	// stage 4: interpolate z and r
	logic signed [32:0] zp, rp;
	logic signed [15:0] zsum, rsum;
	logic [12:0]        z_s4, r_s4;
	logic signed [15:0] c_s4, wxg_s4, bxg_s4, hp_s4;
	logic               keep_s4;

	assign zp   = 33'(zd_s3 * $signed({1'b0, zf_s3})) + 33'sd32768;
	assign rp   = 33'(rd_s3 * $signed({1'b0, rf_s3})) + 33'sd32768;
	assign zsum = $signed({3'b0, zt0_s3}) + $signed(zp[31:16]);
	assign rsum = $signed({3'b0, rt0_s3}) + $signed(rp[31:16]);

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			z_s4    <= zsum[12:0];
			r_s4    <= rsum[12:0];
			c_s4    <= c_s3;
			wxg_s4  <= wxg_s3;
			bxg_s4  <= bxg_s3;
			hp_s4   <= hp_s3;
			keep_s4 <= keep_s3;
		end
	end

	// ---------------------------------------------------------------
	// stage 5: reset gate times recurrent candidate
	logic signed [29:0] rc_s5;
	logic [12:0]        z_s5, r_s5;
	logic signed [15:0] c_s5, wxg_s5, bxg_s5, hp_s5;
	logic               keep_s5;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			rc_s5   <= $signed({1'b0, r_s4}) * c_s4;
			z_s5    <= z_s4;
			r_s5    <= r_s4;
			c_s5    <= c_s4;
			wxg_s5  <= wxg_s4;
			bxg_s5  <= bxg_s4;
			hp_s5   <= hp_s4;
			keep_s5 <= keep_s4;
		end
	end

	// ---------------------------------------------------------------
	// stage 6: candidate pre-activation
	logic signed [15:0] sg_s6, c_s6, hp_s6;
	logic [12:0]        z_s6, r_s6;
	logic               keep_s6;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			sg_s6   <= sat16(32'(wxg_s5) + 32'(round12(32'(rc_s5))) + 32'(bxg_s5));
			z_s6    <= z_s5;
			r_s6    <= r_s5;
			c_s6    <= c_s5;
			hp_s6   <= hp_s5;
			keep_s6 <= keep_s5;
		end
	end

	// ---------------------------------------------------------------
	// stage 7: tanh table fetch
	logic [PW-1:0]      pg;
	logic [IW:0]        ig0, ig1;
	logic [13:0]        gt0_s7;
	logic signed [15:0] gd_s7;
	logic [15:0]        gf_s7;
	logic signed [15:0] c_s7, hp_s7;
	logic [12:0]        z_s7, r_s7;
	logic               keep_s7;

	assign pg  = PW'({~sg_s6[15], sg_s6[14:0]}) * PW'(N);
	assign ig0 = {1'b0, pg[16+IW-1:16]};
	assign ig1 = ig0 + 1'b1;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			gt0_s7  <= gcpu_pkg::TANH_TAB[ig0];
			gd_s7   <= $signed({2'b0, gcpu_pkg::TANH_TAB[ig1]})
				- $signed({2'b0, gcpu_pkg::TANH_TAB[ig0]});
			gf_s7   <= pg[15:0];
			z_s7    <= z_s6;
			r_s7    <= r_s6;
			c_s7    <= c_s6;
			hp_s7   <= hp_s6;
			keep_s7 <= keep_s6;
		end
	end

	// ---------------------------------------------------------------
	// stage 8: interpolate tanh and remove the offset
	logic signed [33:0] gp;
	logic signed [15:0] gsum;
	logic signed [13:0] g_s8;
	logic signed [15:0] c_s8, hp_s8;
	logic [12:0]        z_s8, r_s8;
	logic               keep_s8;

	assign gp   = 34'(gd_s7 * $signed({1'b0, gf_s7})) + 34'sd32768;
	assign gsum = $signed({2'b0, gt0_s7}) + $signed(gp[31:16]) - 16'sd4096;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			g_s8    <= gsum[13:0];
			z_s8    <= z_s7;
			r_s8    <= r_s7;
			c_s8    <= c_s7;
			hp_s8   <= hp_s7;
			keep_s8 <= keep_s7;
		end
	end

	// ---------------------------------------------------------------
	// stage 9: state blend products
	logic signed [13:0] zc;
	logic signed [29:0] pa_s9;
	logic signed [27:0] pb_s9;
	logic signed [13:0] g_s9;
	logic signed [15:0] c_s9, hp_s9;
	logic [12:0]        z_s9, r_s9;
	logic               keep_s9;

	assign zc = 14'sd4096 - $signed({1'b0, z_s8});

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			pa_s9   <= $signed({1'b0, z_s8}) * hp_s8;
			pb_s9   <= zc * g_s8;
			g_s9    <= g_s8;
			z_s9    <= z_s8;
			r_s9    <= r_s8;
			c_s9    <= c_s8;
			hp_s9   <= hp_s8;
			keep_s9 <= keep_s8;
		end
	end

	// ---------------------------------------------------------------
	// stage 10: gru state
	logic signed [15:0] h_s10, hp_s10, c_s10;
	logic signed [13:0] g_s10;
	logic [12:0]        z_s10, r_s10;
	logic               keep_s10;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			h_s10    <= sat16(32'(round12(32'(pa_s9) + 32'(pb_s9))));
			g_s10    <= g_s9;
			z_s10    <= z_s9;
			r_s10    <= r_s9;
			c_s10    <= c_s9;
			hp_s10   <= hp_s9;
			keep_s10 <= keep_s9;
		end
	end

	// ---------------------------------------------------------------
	// stage 11: zoneout blend products, probability clipped to one
	logic [12:0]        zo_p;
	logic signed [29:0] qa_s11, qb_s11;
	logic signed [15:0] h_s11, hp_s11, c_s11;
	logic signed [13:0] g_s11;
	logic [12:0]        z_s11, r_s11;
	logic               keep_s11;

	assign zo_p = (zoneout_probability_q > 13'd4096) ? 13'd4096 : zoneout_probability_q;

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			qa_s11   <= $signed({1'b0, zo_p}) * hp_s10;
			qb_s11   <= $signed({1'b0, 13'd4096 - zo_p}) * h_s10;
			h_s11    <= h_s10;
			g_s11    <= g_s10;
			z_s11    <= z_s10;
			r_s11    <= r_s10;
			c_s11    <= c_s10;
			hp_s11   <= hp_s10;
			keep_s11 <= keep_s10;
		end
	end

	// ---------------------------------------------------------------
	// stage 12: zoneout select, output register
	logic               zo_on;
	logic signed [15:0] h_fin;

	assign zo_on = zoneout_enable_q && (zoneout_probability_q != '0);

	always_comb begin
		priority if (!zo_on) begin
			h_fin = h_s11;
		end else if (training_mode_q) begin
			h_fin = keep_s11 ? h_s11 : hp_s11;
		end else begin
			h_fin = sat16(32'(round12(32'(qa_s11) + 32'(qb_s11))));
		end
	end

	always_ff @(posedge clk) begin
		if (adv[11]) begin
			h_new                   <= h_fin;
			gate_update             <= z_s11;
			gate_reset              <= r_s11;
			gate_candidate          <= g_s11;
			recurrent_candidate_sum <= c_s11;
		end
	end

	// ---------------------------------------------------------------
	// checks
	`include "gru_cell_pointwise_update_core_defines.svh"

	`GCPU_ASSERT_SAME(a_stall_needs_full, in_stall, vld_q[0], "input stalled with empty first stage")
	`GCPU_ASSERT_NEXT(a_write_no_result, in_xfer && (action == gcpu_pkg::ACT_WRITE), !vld_q[0], "bias write entered the pipeline")
	`GCPU_ASSERT_NEXT(a_mid_hold, vld_q[NS/2] && !adv[NS/2], vld_q[NS/2], "stalled stage lost its item")
	`GCPU_ASSERT_SAME(a_gate_range, vld_q[3], (z_s4 <= 13'd4096) && (r_s4 <= 13'd4096), "sigmoid gate above one")
	`GCPU_ASSERT_SAME(a_cand_range, vld_q[7], (g_s8 >= -14'sd4096) && (g_s8 <= 14'sd4096), "tanh out of range")

endmodule
